### src/rad_pkg.sv
// Shared types and constants for the range distinct-check block.
`timescale 1ns / 1ps
`default_nettype none

package rad_pkg;

  // Fixed field widths of the channels and the length register
  localparam int unsigned OP_W   = 1;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned VAL_W  = 16;
  localparam int unsigned LEN_W  = 17;

  // Operation codes carried on the input channel
  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_PICK,
    ST_SEQ_RD,
    ST_KEY,
    ST_CNT_RD,
    ST_CNT_WR,
    ST_LD_WR,
    ST_DONE
  } state_t;

  // Next window move chosen in the pick state
  typedef enum logic [2:0] {
    PICK_GROW_LEFT,
    PICK_GROW_RIGHT,
    PICK_SHRINK_LEFT,
    PICK_SHRINK_RIGHT,
    PICK_NONE
  } pick_t;

  // Command from the sequencer to the count unit
  typedef struct packed {
    logic rd;
    logic wr;
    logic add;
  } cnt_cmd_t;

endpackage

`default_nettype wire

### src/rad_if.sv
// Valid/ready channel interfaces for the input and result transactions.
`timescale 1ns / 1ps
`default_nettype none

interface rad_in_if;
  logic                       valid;
  logic                       ready;
  logic [rad_pkg::OP_W-1:0]   opcode;
  logic [rad_pkg::POS_W-1:0]  position;
  logic [rad_pkg::VAL_W-1:0]  entry_value;
  logic [rad_pkg::POS_W-1:0]  range_left;
  logic [rad_pkg::POS_W-1:0]  range_right;

  modport source (output valid, output opcode, output position, output entry_value,
                  output range_left, output range_right, input ready);
  modport sink   (input valid, input opcode, input position, input entry_value,
                  input range_left, input range_right, output ready);
endinterface

interface rad_out_if;
  logic                       valid;
  logic                       ready;
  logic                       all_distinct;
  logic [rad_pkg::LEN_W-1:0]  distinct_count;
  logic                       query_error;

  modport source (output valid, output all_distinct, output distinct_count,
                  output query_error, input ready);
  modport sink   (input valid, input all_distinct, input distinct_count,
                  input query_error, output ready);
endinterface

`default_nettype wire

### src/rad_count_unit.sv
// Occurrence count memory with clearing pass and running distinct total.
`timescale 1ns / 1ps
`default_nettype none

module rad_count_unit #(
  parameter int unsigned SEQ_DEPTH   = 65536,
  parameter int unsigned VALUE_RANGE = 65536,
  localparam int unsigned KW = $clog2(VALUE_RANGE),
  localparam int unsigned CW = $clog2(SEQ_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rad_pkg::cnt_cmd_t cmd,
  input  logic [KW-1:0]     key,
  output logic              clearing,
  output logic [CW-1:0]     distinct_total
);

  logic [CW-1:0] cnt_mem [VALUE_RANGE];
  logic [CW-1:0] cnt_q_r;
  logic [KW-1:0] key_r;
  logic          clear_r, clear_nxt;
  logic [KW-1:0] clr_idx_r, clr_idx_nxt;
  logic [CW-1:0] dt_r, dt_nxt;
  logic          wr_en;
  logic [KW-1:0] wr_addr;
  logic [CW-1:0] wr_data;

  // Sweep every count entry to zero after reset
  always_comb begin
    clear_nxt   = clear_r;
    clr_idx_nxt = clr_idx_r;
    if (clear_r) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == KW'(VALUE_RANGE - 1)) begin
        clear_nxt = 1'b0;
      end
    end
  end

  // Write zero during the clearing pass, else update the count read last cycle; skip a removal from a zero count
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = key_r;
    wr_data = cnt_q_r;
    dt_nxt  = dt_r;
    if (clear_r) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_r;
      wr_data = '0;
    end else if (cmd.wr) begin
      if (cmd.add) begin
        wr_en   = 1'b1;
        wr_data = cnt_q_r + 1'b1;
        if (cnt_q_r == '0) begin
          dt_nxt = dt_r + 1'b1;
        end
      end else if (cnt_q_r != '0) begin
        wr_en   = 1'b1;
        wr_data = cnt_q_r - 1'b1;
        if (cnt_q_r == CW'(1)) begin
          dt_nxt = dt_r - 1'b1;
        end
      end
    end
  end

  // Count memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cnt_mem[wr_addr] <= wr_data;
    end
    if (cmd.rd) begin
      cnt_q_r <= cnt_mem[key];
      key_r   <= key;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r   <= 1'b1;
      clr_idx_r <= '0;
      dt_r      <= '0;
    end else begin
      clear_r   <= clear_nxt;
      clr_idx_r <= clr_idx_nxt;
      dt_r      <= dt_nxt;
    end
  end

  assign clearing       = clear_r;
  assign distinct_total = dt_r;

  // No count access while the clearing pass owns the memory
  a_no_cmd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> (!cmd.rd && !cmd.wr))
    else $error("count command during clearing pass");

  // Read and update steps never overlap
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |-> !cmd.wr)
    else $error("count read and write in same cycle");

  // Distinct total moves only on an update step
  a_dt_only_on_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (!cmd.wr && !clear_r) |=> $stable(dt_r))
    else $error("distinct total changed without a count update");

endmodule

`default_nettype wire

### src/range_all_distinct_check.sv
// Top level: sequence store, window sequencer and result register.
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+------------------------------------------
//  in_chan | in  | valid/ready         | opcode, position, entry_value, range_left,
//          |     |                     | range_right
//  out_chan| out | valid/ready         | all_distinct, distinct_count, query_error
//  cfg     | in  | cfg_wr_en           | cfg_wr_data (array_length)
//
// After reset the count memory is swept to zero; no transaction is taken meanwhile.
// A load reduces its value modulo VALUE_RANGE by reciprocal multiply; when its position
// lies in the current window the old value is read and removed from the count memory
// and the new one added. Each position a query moves the window ends is one read of the
// sequence memory and one read-modify-write of the count memory. A finished result waits
// in the output register while the next transaction is taken; a query holds in its last
// cycle while that register is full.
`timescale 1ns / 1ps
`default_nettype none

module range_all_distinct_check #(
  parameter int unsigned SEQ_DEPTH   = 65536,
  parameter int unsigned VALUE_RANGE = 65536
) (
  input  logic                      clk,
  input  logic                      rst_n,
  rad_in_if.sink                    in_chan,
  rad_out_if.source                 out_chan,
  input  logic                      cfg_wr_en,
  input  logic [rad_pkg::LEN_W-1:0] cfg_wr_data
);

  localparam int unsigned VAL_W  = rad_pkg::VAL_W;
  localparam int unsigned LEN_W  = rad_pkg::LEN_W;
  localparam int unsigned AW     = $clog2(SEQ_DEPTH);
  localparam int unsigned PW     = $clog2(SEQ_DEPTH + 1);
  localparam int unsigned KW     = $clog2(VALUE_RANGE);
  localparam int unsigned CMPW   = (PW > LEN_W) ? PW : LEN_W;
  // Rounded-up reciprocal of VALUE_RANGE; exact quotient for every VAL_W-bit value
  localparam int unsigned RSH    = VAL_W + KW;
  localparam int unsigned MW     = VAL_W + 2;
  localparam int unsigned PRW    = VAL_W + MW;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << RSH) + 64'(VALUE_RANGE) - 64'd1) / 64'(VALUE_RANGE));

  rad_pkg::state_t   state_r, state_nxt;
  rad_pkg::pick_t    pick;
  rad_pkg::cnt_cmd_t cnt_cmd;

  logic [PW-1:0]      ws_r, we_r;
  logic [PW-1:0]      addr_r;
  logic [VAL_W-1:0]   left_r;
  logic [LEN_W-1:0]   stop_r;
  logic [LEN_W-1:0]   len_r;
  logic               is_load_r;
  logic               add_r;
  logic               res_err_r;
  logic [KW-1:0]      val_r;
  logic [KW-1:0]      key_r;
  logic [VAL_W-1:0]   rem_r;
  logic [VAL_W-1:0]   quo_r, quo_nxt;
  logic               red_ph_r;
  logic [KW-1:0]      seq_rdata_r;
  logic               out_valid_r;
  logic               out_all_r;
  logic [LEN_W-1:0]   out_count_r;
  logic               out_err_r;

  logic               in_ready;
  logic               in_fire;
  logic               pos_ok;
  logic               q_bad;
  logic               reduce_last;
  logic               in_win;
  logic               seq_re, seq_we;
  logic               clearing;
  logic               out_load;
  logic [PW-1:0]      dt;
  logic [CMPW-1:0]    ws_c, we_c, left_c, stop_c, addr_c, pos_c, dt_c;
  logic [PRW-1:0]     quo_prod;
  logic [VAL_W-1:0]   rem_sub;
  logic [KW-1:0]      val_red;

  logic [KW-1:0] seq_mem [SEQ_DEPTH];

  assign in_fire = in_chan.valid && in_ready;

  // Widen positions for comparison
  assign ws_c   = CMPW'(ws_r);
  assign we_c   = CMPW'(we_r);
  assign left_c = CMPW'(left_r);
  assign stop_c = CMPW'(stop_r);
  assign addr_c = CMPW'(addr_r);
  assign pos_c  = CMPW'(in_chan.position);
  assign dt_c   = CMPW'(dt);

  // Screen the incoming transaction
  assign pos_ok = 32'(in_chan.position) < SEQ_DEPTH;
  assign q_bad  = (in_chan.range_left > in_chan.range_right) ||
                  (LEN_W'(in_chan.range_right) >= len_r) ||
                  (32'(in_chan.range_right) >= SEQ_DEPTH);

  // Value modulo VALUE_RANGE: quotient by reciprocal multiply, then subtract back
  assign quo_prod    = PRW'(rem_r) * PRW'(RECIP);
  assign quo_nxt     = VAL_W'(quo_prod >> RSH);
  assign rem_sub     = quo_r * VAL_W'(VALUE_RANGE);
  assign val_red     = KW'(rem_r - rem_sub);
  assign reduce_last = red_ph_r;
  assign in_win      = (addr_c >= ws_c) && (addr_c < we_c);

  // Choose the next window move: widen left, widen right, narrow left, narrow right
  always_comb begin
    priority if (ws_c > left_c) begin
      pick = rad_pkg::PICK_GROW_LEFT;
    end else if (we_c < stop_c) begin
      pick = rad_pkg::PICK_GROW_RIGHT;
    end else if (ws_c < left_c) begin
      pick = rad_pkg::PICK_SHRINK_LEFT;
    end else if (we_c > stop_c) begin
      pick = rad_pkg::PICK_SHRINK_RIGHT;
    end else begin
      pick = rad_pkg::PICK_NONE;
    end
  end

  assign out_load = (state_r == rad_pkg::ST_DONE) && (!out_valid_r || out_chan.ready);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rad_pkg::ST_CLEAR: begin
        if (!clearing) state_nxt = rad_pkg::ST_IDLE;
      end
      rad_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_chan.opcode == rad_pkg::OP_LOAD) begin
            if (pos_ok) state_nxt = rad_pkg::ST_REDUCE;
          end else if (q_bad) begin
            state_nxt = rad_pkg::ST_DONE;
          end else begin
            state_nxt = rad_pkg::ST_PICK;
          end
        end
      end
      rad_pkg::ST_REDUCE: begin
        if (reduce_last) state_nxt = in_win ? rad_pkg::ST_SEQ_RD : rad_pkg::ST_LD_WR;
      end
      rad_pkg::ST_PICK: begin
        state_nxt = (pick == rad_pkg::PICK_NONE) ? rad_pkg::ST_DONE : rad_pkg::ST_SEQ_RD;
      end
      rad_pkg::ST_SEQ_RD: state_nxt = rad_pkg::ST_KEY;
      rad_pkg::ST_KEY:    state_nxt = rad_pkg::ST_CNT_RD;
      rad_pkg::ST_CNT_RD: state_nxt = rad_pkg::ST_CNT_WR;
      rad_pkg::ST_CNT_WR: begin
        if (!is_load_r) begin
          state_nxt = rad_pkg::ST_PICK;
        end else if (add_r) begin
          state_nxt = rad_pkg::ST_LD_WR;
        end else begin
          state_nxt = rad_pkg::ST_CNT_RD;
        end
      end
      rad_pkg::ST_LD_WR:  state_nxt = rad_pkg::ST_IDLE;
      rad_pkg::ST_DONE: begin
        if (out_load) state_nxt = rad_pkg::ST_IDLE;
      end
      default: state_nxt = rad_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready    = 1'b0;
    seq_re      = 1'b0;
    seq_we      = 1'b0;
    cnt_cmd.rd  = 1'b0;
    cnt_cmd.wr  = 1'b0;
    cnt_cmd.add = add_r;
    unique case (state_r)
      rad_pkg::ST_IDLE:   in_ready   = 1'b1;
      rad_pkg::ST_SEQ_RD: seq_re     = 1'b1;
      rad_pkg::ST_CNT_RD: cnt_cmd.rd = 1'b1;
      rad_pkg::ST_CNT_WR: cnt_cmd.wr = 1'b1;
      rad_pkg::ST_LD_WR:  seq_we     = 1'b1;
      default: ;
    endcase
  end

  // Sequence memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (seq_we) begin
      seq_mem[addr_r[AW-1:0]] <= val_r;
    end
    if (seq_re) begin
      seq_rdata_r <= seq_mem[addr_r[AW-1:0]];
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      rad_pkg::ST_IDLE: begin
        if (in_fire) begin
          rem_r     <= in_chan.entry_value;
          red_ph_r  <= 1'b0;
          addr_r    <= pos_c[PW-1:0];
          left_r    <= in_chan.range_left;
          stop_r    <= LEN_W'(in_chan.range_right) + 1'b1;
          res_err_r <= q_bad;
          is_load_r <= (in_chan.opcode == rad_pkg::OP_LOAD);
        end
      end
      rad_pkg::ST_REDUCE: begin
        if (reduce_last) begin
          val_r <= val_red;
          add_r <= 1'b0;
        end else begin
          quo_r    <= quo_nxt;
          red_ph_r <= 1'b1;
        end
      end
      rad_pkg::ST_PICK: begin
        unique case (pick)
          rad_pkg::PICK_GROW_LEFT: begin
            addr_r <= ws_r - 1'b1;
            add_r  <= 1'b1;
          end
          rad_pkg::PICK_GROW_RIGHT: begin
            addr_r <= we_r;
            add_r  <= 1'b1;
          end
          rad_pkg::PICK_SHRINK_LEFT: begin
            addr_r <= ws_r;
            add_r  <= 1'b0;
          end
          rad_pkg::PICK_SHRINK_RIGHT: begin
            addr_r <= we_r - 1'b1;
            add_r  <= 1'b0;
          end
          default: ;
        endcase
      end
      rad_pkg::ST_KEY: key_r <= seq_rdata_r;
      rad_pkg::ST_CNT_WR: begin
        // Load inside the window: old value removed, now add the new one
        if (is_load_r && !add_r) begin
          key_r <= val_r;
          add_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_err_r   <= res_err_r;
      out_all_r   <= !res_err_r && (dt_c == CMPW'(stop_r - LEN_W'(left_r)));
      out_count_r <= res_err_r ? '0 : dt_c[LEN_W-1:0];
    end
  end

  // Control state: sequencer, window ends, length register, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rad_pkg::ST_CLEAR;
      ws_r        <= '0;
      we_r        <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        len_r <= cfg_wr_data;
      end
      if (state_r == rad_pkg::ST_PICK) begin
        unique case (pick)
          rad_pkg::PICK_GROW_LEFT:    ws_r <= ws_r - 1'b1;
          rad_pkg::PICK_GROW_RIGHT:   we_r <= we_r + 1'b1;
          rad_pkg::PICK_SHRINK_LEFT:  ws_r <= ws_r + 1'b1;
          rad_pkg::PICK_SHRINK_RIGHT: we_r <= we_r - 1'b1;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  rad_count_unit #(
    .SEQ_DEPTH   (SEQ_DEPTH),
    .VALUE_RANGE (VALUE_RANGE)
  ) u_count (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cnt_cmd),
    .key            (key_r),
    .clearing       (clearing),
    .distinct_total (dt)
  );

  assign in_chan.ready           = in_ready;
  assign out_chan.valid          = out_valid_r;
  assign out_chan.all_distinct   = out_all_r;
  assign out_chan.distinct_count = out_count_r;
  assign out_chan.query_error    = out_err_r;

  // Window never inverts
  a_window_order: assert property (@(posedge clk) disable iff (!rst_n)
    ws_c <= we_c)
    else $error("window start passed window end");

  // A finished query leaves the window exactly on the requested range
  a_window_on_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rad_pkg::ST_DONE && !res_err_r) |-> (ws_c == left_c && we_c == stop_c))
    else $error("window does not match query range at completion");

  // Rejected queries report nothing else
  a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_count_r == '0 && !out_all_r))
    else $error("error result carries a count");

endmodule

`default_nettype wire

### sim/tb.sv
// Testbench for range_all_distinct_check: loads and range queries checked against a window model.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned FILLED   = 48;  // positions 0..FILLED-1 are loaded before random queries
  localparam int unsigned SETTLE   = 40;  // covers a load still in flight
  localparam int unsigned N_PHASES = 6;
  localparam int unsigned MAX_SHOW = 10;

  // Values loaded at positions 0..7 in the directed part: two duplicate pairs, both extremes
  localparam logic [15:0] START_VALUES [8] = '{16'd5, 16'hFFFF, 16'd5, 16'd0,
                                              16'd1, 16'd2, 16'd3, 16'hFFFF};

  // Per-phase length setting, sender idle and receiver stall percentages, item counts
  localparam int unsigned PHASE_LEN   [N_PHASES] = '{48, 65536, 20, 0, 65535, 1};
  localparam int unsigned PHASE_IDLE  [N_PHASES] = '{0, 51, 0, 6, 6, 0};
  localparam int unsigned PHASE_STALL [N_PHASES] = '{0, 0, 51, 6, 6, 0};
  localparam int unsigned PHASE_ITEMS [N_PHASES] = '{380, 350, 330, 120, 380, 300};

  typedef struct {
    rad_pkg::opcode_t op;
    logic [15:0]      position;
    logic [15:0]      entry_value;
    logic [15:0]      range_left;
    logic [15:0]      range_right;
  } request_t;

  typedef struct {
    logic        all_distinct;
    logic [16:0] distinct_count;
    logic        query_error;
  } answer_t;

  // Window model: sequence store, occurrence counts and the answers still owed by the block
  class distinct_tracker;
    bit [15:0]   seq_mem [65536];
    int unsigned occ [65536];
    int unsigned win_lo, win_hi, n_distinct, length;
    answer_t     owed_answers [$];
    int unsigned n_fail;

    function void set_length(int unsigned v);
      length = v;
    endfunction

    function int unsigned backlog();
      return owed_answers.size();
    endfunction

    function void count_add(bit [15:0] v);
      occ[v]++;
      if (occ[v] == 1) n_distinct++;
    endfunction

    function void count_drop(bit [15:0] v);
      if (occ[v] != 0) begin
        occ[v]--;
        if (occ[v] == 0) n_distinct--;
      end
    endfunction

    function void apply_transaction(request_t t);
      answer_t     a;
      int unsigned lo, stop;
      if (t.op == rad_pkg::OP_LOAD) begin
        // Swap the counts when the entry lies inside the window
        if (t.position >= win_lo && t.position < win_hi) begin
          count_drop(seq_mem[t.position]);
          count_add(t.entry_value);
        end
        seq_mem[t.position] = t.entry_value;
        return;
      end
      lo   = t.range_left;
      stop = t.range_right + 1;
      if (t.range_left > t.range_right || t.range_right >= length) begin
        a = '{1'b0, 17'd0, 1'b1};
      end else begin
        // Widen first, then narrow, one position per step
        while (win_lo > lo) begin
          win_lo--;
          count_add(seq_mem[win_lo]);
        end
        while (win_hi < stop) begin
          count_add(seq_mem[win_hi]);
          win_hi++;
        end
        while (win_lo < lo) begin
          count_drop(seq_mem[win_lo]);
          win_lo++;
        end
        while (win_hi > stop) begin
          win_hi--;
          count_drop(seq_mem[win_hi]);
        end
        a.all_distinct   = (n_distinct == stop - lo);
        a.distinct_count = 17'(n_distinct);
        a.query_error    = 1'b0;
      end
      owed_answers.push_back(a);
    endfunction

    function void check_answer(answer_t got);
      answer_t want;
      if (owed_answers.size() == 0) begin
        n_fail++;
        if (n_fail <= MAX_SHOW)
          $display("%0t: result with no query pending: all_distinct=%0d count=%0d error=%0d",
                   $realtime, got.all_distinct, got.distinct_count, got.query_error);
        return;
      end
      want = owed_answers.pop_front();
      if (got.all_distinct !== want.all_distinct || got.distinct_count !== want.distinct_count ||
          got.query_error !== want.query_error) begin
        n_fail++;
        if (n_fail <= MAX_SHOW)
          $display("%0t: mismatch: expected all_distinct=%0d count=%0d error=%0d, got %0d %0d %0d",
                   $realtime, want.all_distinct, want.distinct_count, want.query_error,
                   got.all_distinct, got.distinct_count, got.query_error);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [rad_pkg::LEN_W-1:0]     cfg_wr_data;
  int unsigned                   send_idle_pct;
  int unsigned                   stall_pct;
  distinct_tracker               sb;

  rad_in_if  in_bus ();
  rad_out_if out_bus ();

  range_all_distinct_check uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_bus),
    .out_chan    (out_bus),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #10 clk = ~clk;

  // Mostly small values so that duplicates are common
  function automatic logic [15:0] pick_value();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 15));
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic request_t load_req(logic [15:0] pos, logic [15:0] value);
    request_t t;
    t.op          = rad_pkg::OP_LOAD;
    t.position    = pos;
    t.entry_value = value;
    t.range_left  = 16'($urandom_range(0, 65535));
    t.range_right = 16'($urandom_range(0, 65535));
    return t;
  endfunction

  function automatic request_t query_req(logic [15:0] left, logic [15:0] right);
    request_t t;
    t.op          = rad_pkg::OP_QUERY;
    t.position    = 16'($urandom_range(0, 65535));
    t.entry_value = 16'($urandom_range(0, 65535));
    t.range_left  = left;
    t.range_right = right;
    return t;
  endfunction

  // Random transaction; accepted queries never reach past the loaded region
  function automatic request_t random_request(int unsigned len);
    request_t    t;
    int unsigned pick, l, r;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      if ($urandom_range(0, 9) < 7) t = load_req(16'($urandom_range(0, FILLED - 1)), pick_value());
      else t = load_req(16'($urandom_range(0, 65535)), pick_value());
    end else if (pick < 85) begin
      l = $urandom_range(0, FILLED - 1);
      r = $urandom_range(l, FILLED - 1);
      t = query_req(16'(l), 16'(r));
    end else if (pick < 92) begin
      r = $urandom_range(0, 65534);
      l = $urandom_range(r + 1, 65535);
      t = query_req(16'(l), 16'(r));
    end else begin
      l = $urandom_range(0, 65535);
      r = ($urandom_range(0, 2) == 0) ? 65535 : $urandom_range(0, 65535);
      // Turn a range that would be accepted outside the loaded region into a reversed one
      if (l <= r && r >= FILLED && r < len) begin
        if (l == r) r = l - 1;
        else {l, r} = {r, l};
      end
      t = query_req(16'(l), 16'(r));
    end
    return t;
  endfunction

  task automatic send(input request_t t);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.opcode      <= t.op;
    in_bus.position    <= t.position;
    in_bus.entry_value <= t.entry_value;
    in_bus.range_left  <= t.range_left;
    in_bus.range_right <= t.range_right;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    sb.apply_transaction(t);
    @(negedge clk);
  endtask

  task automatic write_length(input int unsigned v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[rad_pkg::LEN_W-1:0];
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.set_length(v);
  endtask

  // Drop valid and wait until every owed answer has come and any load has finished
  task automatic drain();
    in_bus.valid <= 1'b0;
    while (sb.backlog() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Receiver: randomly stall ready at each falling edge
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Check every accepted result transaction
  always @(posedge clk) begin : watch_results
    answer_t got;
    if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
      got.all_distinct   = out_bus.all_distinct;
      got.distinct_count = out_bus.distinct_count;
      got.query_error    = out_bus.query_error;
      sb.check_answer(got);
    end
  end

  initial begin
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned ph, k;
    sb                 = new();
    send_idle_pct      = 0;
    stall_pct          = 0;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_bus.valid       = 1'b0;
    in_bus.opcode      = rad_pkg::OP_LOAD;
    in_bus.position    = '0;
    in_bus.entry_value = '0;
    in_bus.range_left  = '0;
    in_bus.range_right = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: small sequence with duplicates, boundary and rejected queries
    write_length(8);
    for (k = 0; k < 8; k++) send(load_req(16'(k), START_VALUES[k]));
    send(load_req(16'hFFFF, 16'h1234));
    send(query_req(16'd0, 16'd0));
    send(query_req(16'd0, 16'd1));
    send(query_req(16'd0, 16'd2));
    send(query_req(16'd3, 16'd6));
    send(query_req(16'd0, 16'd7));
    send(query_req(16'd7, 16'd7));
    send(query_req(16'd2, 16'd1));
    send(query_req(16'd0, 16'd8));
    send(query_req(16'hFFFF, 16'hFFFF));
    send(query_req(16'd0, 16'hFFFF));
    // Loads inside and outside the current window
    send(load_req(16'd7, 16'd9));
    send(query_req(16'd4, 16'd7));
    send(load_req(16'd5, 16'd1));
    send(query_req(16'd3, 16'd6));
    send(load_req(16'd0, 16'd3));

    // Fill the rest of the working region before random queries
    for (k = 8; k < FILLED; k++) send(load_req(16'(k), pick_value()));

    for (ph = 0; ph < N_PHASES; ph++) begin
      drain();
      write_length(PHASE_LEN[ph]);
      send_idle_pct = PHASE_IDLE[ph];
      stall_pct     = PHASE_STALL[ph];
      for (k = 0; k < PHASE_ITEMS[ph]; k++) send(random_request(PHASE_LEN[ph]));
    end
    drain();

    if (sb.n_fail == 0 && sb.backlog() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
